// ===== rtl/core/trcd_pkg.sv =====
// Shared constants, register codes and unit command types for the radial clamp block.
package trcd_pkg;

  localparam int DEFAULT_ADC_BITS   = 12;
  localparam int DEFAULT_COORD_BITS = 16;

  localparam int ADC_REG_W = 12;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 16;

  // shared divide / square-root unit
  localparam int NUM_W    = 48;
  localparam int ROOT_W   = 24;
  localparam int REM_W    = 26;
  localparam int QUO_BITS = 17;
  localparam int CNT_W    = $clog2(ROOT_W + 1);

  // internal signed width of a mapped coordinate
  localparam int VAL_W = 19;

  typedef enum logic [CFG_AW-1:0] {
    REG_ADC_LOW    = 3'd0,
    REG_ADC_HIGH   = 3'd1,
    REG_RADIUS_MIN = 3'd2,
    REG_RADIUS_MAX = 3'd3,
    REG_HEIGHT_MIN = 3'd4,
    REG_HEIGHT_MAX = 3'd5,
    REG_DEBOUNCE   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic              start;
    logic              op_sqrt;
    logic [NUM_W-1:0]  num;
    logic [ROOT_W-1:0] den;
  } unit_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ROOT_W-1:0] result;
  } unit_sts_t;

endpackage

// ===== rtl/core/pot_target_radial_clamp_debounce.sv =====
// Top level: pot sample mapping, annulus clamp and commit button debounce.
//
// Each accepted beat carries four converter samples, a raw button level and a
// millisecond time. The samples are clamped and mapped to x/y (+-radius_max),
// z (height_min..height_max) and grip (0..1 in Q1.15), each with one shared
// multiply and a divide; the divide is skipped when the converter range is
// empty. The x,y point is then pushed onto the annulus radius_min..radius_max
// with a square root and two more divides. The button is debounced as the
// beat is taken. The square root and all divides run on the single
// shift-subtract unit. The input is not ready while an item is in work; a
// finished result waits in the output register while the next item is
// accepted. Configuration writes are always taken.
module pot_target_radial_clamp_debounce #(
  parameter int ADC_BITS   = trcd_pkg::DEFAULT_ADC_BITS,
  parameter int COORD_BITS = trcd_pkg::DEFAULT_COORD_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [trcd_pkg::CFG_AW-1:0] cfg_index_i,
  input  logic [trcd_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ADC_BITS-1:0]         sample_x_i,
  input  logic [ADC_BITS-1:0]         sample_y_i,
  input  logic [ADC_BITS-1:0]         sample_z_i,
  input  logic [ADC_BITS-1:0]         sample_grip_i,
  input  logic                        button_level_i,
  input  logic [31:0]                 time_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [COORD_BITS-1:0] target_x_o,
  output logic signed [COORD_BITS-1:0] target_y_o,
  output logic signed [COORD_BITS-1:0] target_z_o,
  output logic [15:0]                 grip_level_o,
  output logic                        commit_edge_o,
  output logic                        commit_held_o
);
  import trcd_pkg::*;

  localparam int AW = (ADC_BITS > ADC_REG_W) ? ADC_BITS : ADC_REG_W;
  localparam logic [ADC_REG_W-1:0] ADC_MASK =
    (ADC_BITS >= ADC_REG_W) ? {ADC_REG_W{1'b1}} : ADC_REG_W'((1 << ADC_BITS) - 1);
  localparam logic signed [32:0] CMAX = (33'sd1 <<< (COORD_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] CMIN = -CMAX - 33'sd1;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_MAP_MUL  = 14'b00000000000010,
    S_MAP_DIV  = 14'b00000000000100,
    S_MAP_WR   = 14'b00000000001000,
    S_SQ_X     = 14'b00000000010000,
    S_SQ_Y     = 14'b00000000100000,
    S_RMIN_SQ  = 14'b00000001000000,
    S_RMAX_SQ  = 14'b00000010000000,
    S_CHECK    = 14'b00000100000000,
    S_ROOT     = 14'b00001000000000,
    S_CL_MUL   = 14'b00010000000000,
    S_CL_DIV   = 14'b00100000000000,
    S_CL_WR    = 14'b01000000000000,
    S_OUT      = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [ADC_REG_W-1:0] adc_low_q, adc_high_q;
  logic [14:0]          rmin_q, rmax_q;
  logic signed [15:0]   hmin_q, hmax_q;
  logic [7:0]           db_q;

  // debounce state
  logic        prev_raw_q, stable_q, prev_stable_q;
  logic [31:0] chg_time_q;
  logic        pend_edge_q, pend_held_q;

  // item work registers
  logic [AW-1:0]           samp_q [4];
  logic [1:0]              ch_q, ch_d;
  logic signed [VAL_W-1:0] val_q [4];
  logic signed [VAL_W-1:0] lo_q;
  logic                    neg_q, skip_q;
  logic [NUM_W-1:0]        num_q;
  logic [ROOT_W-1:0]       den_q;
  logic                    start_q, op_sqrt_q;
  logic [31:0]             s_q;
  logic [29:0]             rmin_sq_q, rmax_sq_q;
  logic [14:0]             limit_q;
  logic [ROOT_W-1:0]       root_q;

  // output register
  logic                        out_valid_q;
  logic signed [COORD_BITS-1:0] tx_q, ty_q, tz_q;
  logic [15:0]                 grip_q;
  logic                        edge_q, held_q;

  unit_cmd_t unit_cmd;
  unit_sts_t unit_sts;

  trcd_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (unit_cmd),
    .sts_o  (unit_sts)
  );

  assign unit_cmd.start   = start_q;
  assign unit_cmd.op_sqrt = op_sqrt_q;
  assign unit_cmd.num     = num_q;
  assign unit_cmd.den     = den_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);

  function automatic logic signed [COORD_BITS-1:0] sat_coord(logic signed [VAL_W-1:0] v);
    logic signed [32:0] w;
    w = 33'(v);
    if (w > CMAX) w = CMAX;
    if (w < CMIN) w = CMIN;
    return w[COORD_BITS-1:0];
  endfunction

  // shared multiplier
  logic [16:0] mul_a, mul_b;
  logic [33:0] prod;
  assign prod = mul_a * mul_b;

  // mapping operands for the current channel
  logic [AW-1:0]           a_ext, b_ext, c_clamp;
  logic [ADC_REG_W-1:0]    c_diff, range_w;
  logic                    empty_rng;
  logic signed [VAL_W-1:0] map_lo;
  logic [16:0]             span_mag;
  logic                    span_neg;
  logic signed [16:0]      hspan;
  logic [16:0]             quo;
  logic signed [VAL_W-1:0] sq_val, cur_val, abs_val;

  always_comb begin
    a_ext     = AW'(adc_low_q);
    b_ext     = AW'(adc_high_q);
    empty_rng = (adc_high_q <= adc_low_q);
    c_clamp   = samp_q[ch_q];
    if (c_clamp < a_ext) c_clamp = a_ext;
    if (c_clamp > b_ext) c_clamp = b_ext;
    c_diff  = ADC_REG_W'(c_clamp - a_ext);
    range_w = adc_high_q - adc_low_q;
    hspan   = 17'(hmax_q) - 17'(hmin_q);
    case (ch_q)
      2'd0, 2'd1: begin
        map_lo   = -$signed(VAL_W'(rmax_q));
        span_mag = {1'b0, rmax_q, 1'b0};
        span_neg = 1'b0;
      end
      2'd2: begin
        map_lo   = VAL_W'(hmin_q);
        span_neg = hspan[16];
        span_mag = span_neg ? 17'(-hspan) : 17'(hspan);
      end
      default: begin
        map_lo   = '0;
        span_mag = 17'd32768;
        span_neg = 1'b0;
      end
    endcase
    quo     = unit_sts.result[QUO_BITS-1:0];
    sq_val  = neg_q ? -$signed(VAL_W'(quo)) : $signed(VAL_W'(quo));
    cur_val = val_q[ch_q];
    abs_val = cur_val[VAL_W-1] ? -cur_val : cur_val;

    mul_a = 17'(c_diff);
    mul_b = span_mag;
    case (state_q)
      S_SQ_X: begin
        mul_a = val_q[0][VAL_W-1] ? 17'(-val_q[0]) : 17'(val_q[0]);
        mul_b = mul_a;
      end
      S_SQ_Y: begin
        mul_a = val_q[1][VAL_W-1] ? 17'(-val_q[1]) : 17'(val_q[1]);
        mul_b = mul_a;
      end
      S_RMIN_SQ: begin
        mul_a = 17'(rmin_q);
        mul_b = 17'(rmin_q);
      end
      S_RMAX_SQ: begin
        mul_a = 17'(rmax_q);
        mul_b = 17'(rmax_q);
      end
      S_CL_MUL: begin
        mul_a = 17'(abs_val);
        mul_b = 17'(limit_q);
      end
      default: ;
    endcase
  end

  // debounce at accept
  logic        raw_chg, stable_nx;
  logic [31:0] chg_nx, age;
  always_comb begin
    raw_chg   = (button_level_i != prev_raw_q);
    chg_nx    = raw_chg ? time_ms_i : chg_time_q;
    age       = time_ms_i - chg_nx;
    stable_nx = (age > 32'(db_q)) ? button_level_i : stable_q;
  end

  logic in_fire, out_load;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    case (state_q)
      S_IDLE: if (in_fire) begin
        state_d = S_MAP_MUL;
        ch_d    = 2'd0;
      end
      S_MAP_MUL: state_d = empty_rng ? S_MAP_WR : S_MAP_DIV;
      S_MAP_DIV: if (unit_sts.done) state_d = S_MAP_WR;
      S_MAP_WR: begin
        if (ch_q == 2'd3) begin
          state_d = S_SQ_X;
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = S_MAP_MUL;
        end
      end
      S_SQ_X:    state_d = S_SQ_Y;
      S_SQ_Y:    state_d = S_RMIN_SQ;
      S_RMIN_SQ: state_d = S_RMAX_SQ;
      S_RMAX_SQ: state_d = S_CHECK;
      S_CHECK: begin
        if (s_q == '0) begin
          state_d = S_OUT;
        end else if (s_q < 32'(rmin_sq_q) || s_q > 32'(rmax_sq_q)) begin
          state_d = S_ROOT;
        end else begin
          state_d = S_OUT;
        end
      end
      S_ROOT: if (unit_sts.done) begin
        state_d = S_CL_MUL;
        ch_d    = 2'd0;
      end
      S_CL_MUL: state_d = S_CL_DIV;
      S_CL_DIV: if (unit_sts.done) state_d = S_CL_WR;
      S_CL_WR: begin
        if (ch_q == 2'd1) begin
          state_d = S_OUT;
        end else begin
          ch_d    = 2'd1;
          state_d = S_CL_MUL;
        end
      end
      S_OUT: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      ch_q          <= '0;
      start_q       <= 1'b0;
      op_sqrt_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      adc_low_q     <= '0;
      adc_high_q    <= ADC_REG_W'(1023) & ADC_MASK;
      rmin_q        <= 15'd800;
      rmax_q        <= 15'd3200;
      hmin_q        <= '0;
      hmax_q        <= 16'sd3200;
      db_q          <= 8'd30;
      prev_raw_q    <= 1'b0;
      stable_q      <= 1'b0;
      prev_stable_q <= 1'b0;
      chg_time_q    <= '0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      start_q     <= 1'b0;
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_ADC_LOW:    adc_low_q  <= cfg_data_i[ADC_REG_W-1:0] & ADC_MASK;
          REG_ADC_HIGH:   adc_high_q <= cfg_data_i[ADC_REG_W-1:0] & ADC_MASK;
          REG_RADIUS_MIN: rmin_q     <= cfg_data_i[14:0];
          REG_RADIUS_MAX: rmax_q     <= cfg_data_i[14:0];
          REG_HEIGHT_MIN: hmin_q     <= $signed(cfg_data_i);
          REG_HEIGHT_MAX: hmax_q     <= $signed(cfg_data_i);
          REG_DEBOUNCE:   db_q       <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        prev_raw_q    <= button_level_i;
        chg_time_q    <= chg_nx;
        stable_q      <= stable_nx;
        prev_stable_q <= stable_nx;
      end

      // launch the shared unit
      if (state_q == S_MAP_MUL && !empty_rng) begin
        start_q   <= 1'b1;
        op_sqrt_q <= 1'b0;
      end
      if (state_q == S_CHECK && state_d == S_ROOT) begin
        start_q   <= 1'b1;
        op_sqrt_q <= 1'b1;
      end
      if (state_q == S_CL_MUL) begin
        start_q   <= 1'b1;
        op_sqrt_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      samp_q[0]   <= AW'(sample_x_i);
      samp_q[1]   <= AW'(sample_y_i);
      samp_q[2]   <= AW'(sample_z_i);
      samp_q[3]   <= AW'(sample_grip_i);
      pend_edge_q <= stable_nx && !prev_stable_q;
      pend_held_q <= stable_nx;
    end
    case (state_q)
      S_MAP_MUL: begin
        lo_q   <= map_lo;
        neg_q  <= span_neg;
        skip_q <= empty_rng;
        num_q  <= NUM_W'(prod) + NUM_W'(range_w >> 1);
        den_q  <= ROOT_W'(range_w);
      end
      S_MAP_WR:  val_q[ch_q] <= skip_q ? lo_q : lo_q + sq_val;
      S_SQ_X:    s_q <= prod[31:0];
      S_SQ_Y:    s_q <= s_q + prod[31:0];
      S_RMIN_SQ: rmin_sq_q <= prod[29:0];
      S_RMAX_SQ: rmax_sq_q <= prod[29:0];
      S_CHECK: begin
        if (s_q == '0) begin
          val_q[0] <= VAL_W'(rmin_q);
          val_q[1] <= '0;
        end
        // inner test first: it wins when the annulus is inverted
        limit_q <= (s_q < 32'(rmin_sq_q)) ? rmin_q : rmax_q;
        num_q   <= NUM_W'(s_q) << 16;
      end
      S_ROOT: if (unit_sts.done) root_q <= unit_sts.result;
      S_CL_MUL: begin
        neg_q <= cur_val[VAL_W-1];
        num_q <= (NUM_W'(prod) << 8) + NUM_W'(root_q >> 1);
        den_q <= root_q;
      end
      S_CL_WR: val_q[ch_q] <= sq_val;
      default: ;
    endcase
    if (out_load) begin
      tx_q   <= sat_coord(val_q[0]);
      ty_q   <= sat_coord(val_q[1]);
      tz_q   <= sat_coord(val_q[2]);
      grip_q <= val_q[3][15:0];
      edge_q <= pend_edge_q;
      held_q <= pend_held_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign target_x_o    = tx_q;
  assign target_y_o    = ty_q;
  assign target_z_o    = tz_q;
  assign grip_level_o  = grip_q;
  assign commit_edge_o = edge_q;
  assign commit_held_o = held_q;

endmodule

// ===== rtl/core/trcd_unit.sv =====
// Shared one-bit-per-cycle restoring divider and square-root unit.
module trcd_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trcd_pkg::unit_cmd_t cmd_i,
  output trcd_pkg::unit_sts_t sts_o
);
  import trcd_pkg::*;

  logic [REM_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  acc_q, acc_d;
  logic [ROOT_W-1:0] res_q, res_d;
  logic [ROOT_W-1:0] den_q, den_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              sqrt_q, sqrt_d;

  logic [REM_W:0] t_val, trial, diff;
  logic           ge;

  always_comb begin
    if (sqrt_q) begin
      t_val = {rem_q[REM_W-2:0], acc_q[NUM_W-1 -: 2]};
      trial = {1'b0, res_q, 2'b01};
    end else begin
      t_val = {1'b0, rem_q[REM_W-2:0], acc_q[NUM_W-1]};
      trial = {(REM_W + 1 - ROOT_W)'(0), den_q};
    end
    ge   = (t_val >= trial);
    diff = t_val - trial;
  end

  always_comb begin
    rem_d  = rem_q;
    acc_d  = acc_q;
    res_d  = res_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    sqrt_d = sqrt_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      sqrt_d = cmd_i.op_sqrt;
      den_d  = cmd_i.den;
      res_d  = '0;
      if (cmd_i.op_sqrt) begin
        rem_d = '0;
        acc_d = cmd_i.num;
        cnt_d = CNT_W'(ROOT_W);
      end else begin
        // high part is below the divisor, low part feeds quotient bits
        rem_d = REM_W'(cmd_i.num >> QUO_BITS);
        acc_d = cmd_i.num << (NUM_W - QUO_BITS);
        cnt_d = CNT_W'(QUO_BITS);
      end
    end else if (busy_q) begin
      rem_d = ge ? diff[REM_W-1:0] : t_val[REM_W-1:0];
      res_d = {res_q[ROOT_W-2:0], ge};
      acc_d = sqrt_q ? (acc_q << 2) : (acc_q << 1);
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      sqrt_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      sqrt_q <= sqrt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    acc_q <= acc_d;
    res_q <= res_d;
    den_q <= den_d;
  end

  assign sts_o.busy   = busy_q;
  assign sts_o.done   = done_q;
  assign sts_o.result = res_q;

endmodule

// ===== tb/tb_pot_target_radial_clamp_debounce.sv =====
`timescale 1ns / 1ps
// Testbench for the pot target block: self-checking predictor, directed table, random phases.
module tb_pot_target_radial_clamp_debounce;
  import trcd_pkg::*;

  localparam int WDOG_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLDOFF      = 3000;
  localparam int PHASES       = 11;
  localparam int PHASE_ITEMS  = 150;
  localparam int N_ROWS       = 16;

  typedef struct packed {
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] tz;
    logic [15:0]        grip;
    logic               rise;
    logic               held;
  } target_t;

  typedef struct {
    logic [11:0] sx, sy, sz, sg;
    logic        btn;
    logic [31:0] tms;
    logic        typed;
    logic signed [15:0] ez;
    logic [15:0] eg;
    logic        eheld, erise;
  } pot_row_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_AW-1:0] cfg_index_i;
  logic [CFG_DW-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [11:0] sample_x_i, sample_y_i, sample_z_i, sample_grip_i;
  logic button_level_i;
  logic [31:0] time_ms_i;
  logic out_valid_o, out_ready_i;
  logic signed [15:0] target_x_o, target_y_o, target_z_o;
  logic [15:0] grip_level_o;
  logic commit_edge_o, commit_held_o;

  pot_target_radial_clamp_debounce uut (.*);

  // predictor copy of registers and debounce state
  logic [11:0] m_adc_lo, m_adc_hi;
  logic [14:0] m_rmin, m_rmax;
  logic signed [15:0] m_hmin, m_hmax;
  logic [7:0]  m_dbc;
  logic        db_raw, db_stable, db_prev;
  logic [31:0] db_since;

  target_t target_q[$];
  int      mismatches;
  int      idle_cycles;
  logic    hold_req, calm, row_typed;
  pot_row_t cur_row;
  pot_row_t rows[N_ROWS];
  logic [15:0] cfg_plan[4][7];

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint map_pot(longint s, longint lo, longint hi);
    longint a, b, c;
    a = m_adc_lo;
    b = m_adc_hi;
    c = s;
    if (b <= a) return lo;
    if (c < a) c = a;
    if (c > b) c = b;
    return lo + round_div((c - a) * (hi - lo), b - a);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bit_v, rem;
    res   = 0;
    rem   = v;
    bit_v = 64'd1 << 62;
    while (bit_v > rem) bit_v >>= 2;
    while (bit_v != 0) begin
      if (rem >= res + bit_v) begin
        rem -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // advances the debounce state, so call once per accepted beat
  function automatic target_t predict_target(pot_row_t r);
    target_t t;
    longint rmx, rmn, x, y, z, g, lim, rt;
    longint unsigned s;
    logic [31:0] dt;
    rmx = m_rmax;
    rmn = m_rmin;
    x = map_pot(r.sx, -rmx, rmx);
    y = map_pot(r.sy, -rmx, rmx);
    z = map_pot(r.sz, longint'(m_hmin), longint'(m_hmax));
    g = map_pot(r.sg, 0, 32768);
    s = x * x + y * y;
    if (s == 0) begin
      x = rmn;
      y = 0;
    end else begin
      lim = -1;
      if (s < rmn * rmn) lim = rmn;
      else if (s > rmx * rmx) lim = rmx;
      if (lim >= 0) begin
        rt = int_sqrt(s << 16);
        x = round_div(x * lim * 256, rt);
        y = round_div(y * lim * 256, rt);
      end
    end
    if (r.btn != db_raw) begin
      db_raw   = r.btn;
      db_since = r.tms;
    end
    dt = r.tms - db_since;
    if (dt > {24'd0, m_dbc}) db_stable = r.btn;
    t.rise  = db_stable && !db_prev;
    db_prev = db_stable;
    t.tx   = 16'(sat16(x));
    t.ty   = 16'(sat16(y));
    t.tz   = 16'(sat16(z));
    t.grip = 16'(g);
    t.held = db_stable;
    return t;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // scoreboard and watchdog
  always @(posedge clk_i) begin
    target_t e, a;
    if (rst_ni && in_valid_i && in_ready_o) begin
      e = predict_target(cur_row);
      if (row_typed) begin
        e.tz   = cur_row.ez;
        e.grip = cur_row.eg;
        e.held = cur_row.eheld;
        e.rise = cur_row.erise;
      end
      target_q.push_back(e);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      a = '{target_x_o, target_y_o, target_z_o, grip_level_o, commit_edge_o, commit_held_o};
      if (target_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", a);
      end else begin
        e = target_q.pop_front();
        if (a !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, a);
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random back-pressure, one long holdoff on request
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HOLDOFF) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  task automatic send_pot(pot_row_t r);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    cur_row        = r;
    row_typed      = r.typed;
    sample_x_i     = r.sx;
    sample_y_i     = r.sy;
    sample_z_i     = r.sz;
    sample_grip_i  = r.sg;
    button_level_i = r.btn;
    time_ms_i      = r.tms;
    in_valid_i     = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ADC_LOW:    m_adc_lo = data[11:0];
      REG_ADC_HIGH:   m_adc_hi = data[11:0];
      REG_RADIUS_MIN: m_rmin   = data[14:0];
      REG_RADIUS_MAX: m_rmax   = data[14:0];
      REG_HEIGHT_MIN: m_hmin   = data;
      REG_HEIGHT_MAX: m_hmax   = data;
      REG_DEBOUNCE:   m_dbc    = data[7:0];
      default: ;
    endcase
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (target_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [11:0] pick_pot(logic near_mid);
    int lo, hi, v;
    lo = m_adc_lo;
    hi = m_adc_hi;
    if (near_mid) v = (lo + hi) / 2 + $urandom_range(0, 8) - 4;
    else begin
      case ($urandom_range(0, 9))
        0: v = 0;
        1: v = 4095;
        2: v = lo + $urandom_range(0, 3) - 1;
        3: v = hi + $urandom_range(0, 3) - 2;
        4: v = (lo + hi) / 2 + $urandom_range(0, 6) - 3;
        9: v = $urandom_range(0, 4095);
        default: v = (lo < hi) ? lo + $urandom_range(0, hi - lo) : $urandom_range(0, 4095);
      endcase
    end
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  function automatic pot_row_t mk_row(int sx, int sy, int sz, int sg, logic btn,
                                      logic [31:0] tms, logic typed, int ez, int eg,
                                      logic eheld, logic erise);
    pot_row_t r;
    r = '{12'(sx), 12'(sy), 12'(sz), 12'(sg), btn, tms, typed, 16'(ez), 16'(eg), eheld, erise};
    return r;
  endfunction

  initial begin
    pot_row_t r;
    logic [31:0] now_ms;
    logic btn, pair;
    int lo, rmn;

    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = REG_ADC_LOW; cfg_data_i = '0;
    in_valid_i = 1'b0; sample_x_i = '0; sample_y_i = '0; sample_z_i = '0;
    sample_grip_i = '0; button_level_i = 1'b0; time_ms_i = '0;
    hold_req = 1'b0; calm = 1'b0; row_typed = 1'b0; cur_row = '{default: '0};
    mismatches = 0; idle_cycles = 0;
    m_adc_lo = 0; m_adc_hi = 1023; m_rmin = 800; m_rmax = 3200;
    m_hmin = 0; m_hmax = 3200; m_dbc = 30;
    db_raw = 0; db_stable = 0; db_prev = 0; db_since = 0;

    // after reset: range extremes, debounce press, release across the time wrap
    rows[0]  = mk_row(0, 0, 0, 0, 0, 5, 1, 0, 0, 0, 0);
    rows[1]  = mk_row(1023, 1023, 1023, 1023, 0, 10, 1, 3200, 32768, 0, 0);
    rows[2]  = mk_row(4095, 4095, 4095, 4095, 0, 20, 1, 3200, 32768, 0, 0);
    rows[3]  = mk_row(0, 1023, 0, 0, 1, 100, 1, 0, 0, 0, 0);
    rows[4]  = mk_row(1023, 0, 0, 0, 1, 131, 1, 0, 0, 1, 1);
    rows[5]  = mk_row(512, 0, 0, 0, 1, 132, 1, 0, 0, 1, 0);
    rows[6]  = mk_row(0, 512, 0, 0, 0, 32'hFFFF_FFF0, 1, 0, 0, 1, 0);
    rows[7]  = mk_row(300, 700, 0, 0, 0, 32'h0000_0020, 1, 0, 0, 0, 0);
    rows[8]  = mk_row(511, 511, 511, 511, 1, 32'h21, 0, 0, 0, 0, 0);
    rows[9]  = mk_row(512, 512, 512, 512, 0, 32'h22, 0, 0, 0, 0, 0);
    rows[10] = mk_row(511, 512, 100, 900, 0, 32'h80, 0, 0, 0, 0, 0);
    rows[11] = mk_row(520, 505, 700, 1, 1, 32'h90, 0, 0, 0, 0, 0);
    rows[12] = mk_row(4095, 0, 4095, 0, 1, 32'hB0, 0, 0, 0, 0, 0);
    rows[13] = mk_row(800, 200, 2000, 3000, 1, 32'hB0, 0, 0, 0, 0, 0);
    rows[14] = mk_row(1023, 1023, 0, 4095, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
    rows[15] = mk_row(0, 0, 4095, 2048, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);

    cfg_plan[0] = '{16'd0, 16'd4095, 16'd0, 16'd32767, 16'h8000, 16'h7FFF, 16'd0};
    cfg_plan[1] = '{16'd4095, 16'd0, 16'd100, 16'd50, 16'h7FFF, 16'h8000, 16'd255};
    cfg_plan[2] = '{16'd1000, 16'd1000, 16'd800, 16'd0, 16'd0, 16'd0, 16'd30};
    cfg_plan[3] = '{16'd100, 16'd3000, 16'd32767, 16'd32767, 16'hFFF0, 16'h0010, 16'd1};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) send_pot(rows[i]);
    drain_results();

    now_ms = 32'h200;
    btn = 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 4) begin
        for (int k = 0; k < 7; k++) write_reg(cfg_reg_e'(k), cfg_plan[ph][k]);
      end else begin
        lo  = $urandom_range(0, 3000);
        rmn = $urandom_range(0, 32767);
        write_reg(REG_ADC_LOW, {4'($urandom), 12'(lo)});
        write_reg(REG_ADC_HIGH, {4'($urandom), 12'(lo + $urandom_range(1, 4095 - lo))});
        write_reg(REG_RADIUS_MIN, 16'($urandom_range(0, 7) == 0 ? rmn : rmn / 8));
        write_reg(REG_RADIUS_MAX, 16'($urandom));
        write_reg(REG_HEIGHT_MIN, 16'($urandom));
        write_reg(REG_HEIGHT_MAX, 16'($urandom));
        write_reg(REG_DEBOUNCE, 16'($urandom));
      end
      @(negedge clk_i);
      cfg_valid_i = 1'b0;
      if (ph == 1) hold_req = 1'b1;
      if (ph == PHASES - 1) calm = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 7) == 0) btn = ~btn;
        case ($urandom_range(0, 19))
          0:       now_ms = $urandom;
          1:       now_ms = 32'hFFFF_FFFF - $urandom_range(0, 20);
          default: now_ms = now_ms + $urandom_range(0, m_dbc / 4 + 3);
        endcase
        pair = ($urandom_range(0, 3) == 0);
        r = mk_row(pick_pot(pair), pick_pot(pair), pick_pot(0), pick_pot(0), btn, now_ms,
                   0, 0, 0, 0, 0);
        send_pot(r);
      end
      drain_results();
    end

    if (mismatches == 0 && target_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/trcd_pkg.sv
rtl/core/trcd_unit.sv
rtl/core/pot_target_radial_clamp_debounce.sv
tb/tb_pot_target_radial_clamp_debounce.sv
